### src/fmmd_pkg.sv
// Shared types, constants and register codes for the min/max waveform decimator.
`default_nettype none

package fmmd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAX_CH   = 8;
	localparam int CH_W     = 3;
	localparam int NCH_W    = 4;
	localparam int FPB_W    = 24;
	localparam int BKT_W    = 20;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKETS  = 2'd2;

	// result kinds
	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_STEREO  = 1'b1;

	typedef struct packed {
		sample_t            sample;
		logic [CH_W-1:0]    chan;
		logic [NCH_W-1:0]   nch;
		logic               stereo;
		logic               close;
		logic [BKT_W-1:0]   bucket;
	} cmd_t;

	typedef struct packed {
		logic [BKT_W-1:0]   bucket;
		logic               kind;
		logic [CH_W-1:0]    channel;
		sample_t            low;
		sample_t            high;
		sample_t            side_low;
		sample_t            side_high;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

### src/fmmd_fifo.sv
// First-word-fall-through queue used between the front, the back and the result port.
`default_nettype none

module fmmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/fmmd_front.sv
// Front end: configuration registers, channel/frame/bucket tracking and command issue.
`default_nettype none

module fmmd_front import fmmd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 push,
	input  wire sample_t              sample,
	input  wire logic                 cmd_full,
	output logic                      cmd_push,
	output cmd_t                      cmd
);

	logic [NCH_W-1:0] chan_cnt_q;
	logic [FPB_W-1:0] fpb_q;
	logic [BKT_W-1:0] bkt_lim_q;
	logic [CH_W-1:0]  chpos_q;
	logic [FPB_W-1:0] fpos_q;
	logic [BKT_W-1:0] bkt_q;

	logic [NCH_W-1:0] n_eff;
	logic [FPB_W-1:0] fpb_eff;
	logic             active;
	logic [CH_W-1:0]  chan;
	logic             frame_end;
	logic [FPB_W-1:0] fpos_nx;
	logic             close;

	always_comb begin
		if (chan_cnt_q == '0) begin
			n_eff = NCH_W'(1);
		end else if (chan_cnt_q > NCH_W'(MAX_CH)) begin
			n_eff = NCH_W'(MAX_CH);
		end else begin
			n_eff = chan_cnt_q;
		end
	end

	assign fpb_eff   = (fpb_q == '0) ? FPB_W'(1) : fpb_q;
	assign active    = (bkt_q < bkt_lim_q);
	// a stale position after a channel count change restarts the frame
	assign chan      = ({1'b0, chpos_q} >= n_eff) ? '0 : chpos_q;
	assign frame_end = (({1'b0, chan} + NCH_W'(1)) >= n_eff);
	assign fpos_nx   = fpos_q + FPB_W'(1);
	assign close     = frame_end && ((fpos_nx >= fpb_eff) || (fpos_nx == '0));

	// samples past the last bucket are taken and dropped
	assign cmd_push = push && !cmd_full && active;

	always_comb begin
		cmd.sample = sample;
		cmd.chan   = chan;
		cmd.nch    = n_eff;
		cmd.stereo = (n_eff == NCH_W'(2));
		cmd.close  = close;
		cmd.bucket = bkt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= NCH_W'(2);
			fpb_q      <= FPB_W'(1);
			bkt_lim_q  <= '0;
			chpos_q    <= '0;
			fpos_q     <= '0;
			bkt_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CHANNELS: begin
						chan_cnt_q <= cfg_data[NCH_W-1:0];
					end
					REG_FRAMES: begin
						fpb_q <= cfg_data[FPB_W-1:0];
					end
					REG_BUCKETS: begin
						bkt_lim_q <= cfg_data[BKT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd_push) begin
				if (frame_end) begin
					chpos_q <= '0;
					fpos_q  <= close ? '0 : fpos_nx;
					if (close) begin
						bkt_q <= bkt_q + BKT_W'(1);
					end
				end else begin
					chpos_q <= chan + CH_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/fmmd_back.sv
// Back end: min/max accumulators, mid/side tracking and the bucket result sequencer.
`default_nettype none

module fmmd_back import fmmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_empty,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	input  wire logic res_full,
	output logic      res_push,
	output res_t      res
);

	typedef enum logic [2:0] {
		ST_TAKE   = 3'b001,
		ST_EMIT   = 3'b010,
		ST_STEREO = 3'b100
	} state_t;

	state_t           state_q;
	sample_t          cmin_q [MAX_CH];
	sample_t          cmax_q [MAX_CH];
	sample_t          mid_min_q;
	sample_t          mid_max_q;
	sample_t          side_min_q;
	sample_t          side_max_q;
	sample_t          held_q;
	logic [CH_W-1:0]  k_q;
	logic [NCH_W-1:0] nch_q;
	logic             stereo_q;
	logic [BKT_W-1:0] bkt_q;

	logic [CH_W-1:0]     rd_idx;
	sample_t             rd_min;
	sample_t             rd_max;
	logic [SAMPLE_W:0]   sum_w;
	logic [SAMPLE_W:0]   diff_w;
	sample_t             mid;
	sample_t             side;
	logic                k_is_last;
	logic                emit_st;

	assign rd_idx = (state_q == ST_EMIT) ? k_q : cmd.chan;
	assign rd_min = cmin_q[rd_idx];
	assign rd_max = cmax_q[rd_idx];

	// floor halving: drop the low bit of the sign-extended sum
	assign sum_w  = {held_q[SAMPLE_W-1], held_q} + {cmd.sample[SAMPLE_W-1], cmd.sample};
	assign diff_w = {held_q[SAMPLE_W-1], held_q} - {cmd.sample[SAMPLE_W-1], cmd.sample};
	assign mid    = sum_w[SAMPLE_W:1];
	assign side   = diff_w[SAMPLE_W:1];

	assign k_is_last = (({1'b0, k_q} + NCH_W'(1)) == nch_q);
	assign emit_st   = (state_q == ST_EMIT) || (state_q == ST_STEREO);
	assign cmd_pop   = (state_q == ST_TAKE) && !cmd_empty;
	assign res_push  = emit_st && !res_full;

	always_comb begin
		res.bucket = bkt_q;
		if (state_q == ST_STEREO) begin
			res.kind      = KIND_STEREO;
			res.channel   = '0;
			res.low       = mid_min_q;
			res.high      = mid_max_q;
			res.side_low  = side_min_q;
			res.side_high = side_max_q;
			res.last      = 1'b1;
		end else begin
			res.kind      = KIND_CHANNEL;
			res.channel   = k_q;
			res.low       = rd_min;
			res.high      = rd_max;
			res.side_low  = '0;
			res.side_high = '0;
			res.last      = !stereo_q && k_is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_TAKE;
			for (int i = 0; i < MAX_CH; i++) begin
				cmin_q[i] <= SAMPLE_MAX;
				cmax_q[i] <= SAMPLE_MIN;
			end
			mid_min_q  <= SAMPLE_MAX;
			mid_max_q  <= SAMPLE_MIN;
			side_min_q <= SAMPLE_MAX;
			side_max_q <= SAMPLE_MIN;
			held_q     <= '0;
			k_q        <= '0;
			nch_q      <= '0;
			stereo_q   <= 1'b0;
			bkt_q      <= '0;
		end else begin
			unique case (state_q)
				ST_TAKE: begin
					if (cmd_pop) begin
						if (cmd.sample < rd_min) begin
							cmin_q[cmd.chan] <= cmd.sample;
						end
						if (cmd.sample > rd_max) begin
							cmax_q[cmd.chan] <= cmd.sample;
						end
						if (cmd.stereo) begin
							if (cmd.chan == '0) begin
								held_q <= cmd.sample;
							end else begin
								if (mid < mid_min_q) mid_min_q <= mid;
								if (mid > mid_max_q) mid_max_q <= mid;
								if (side < side_min_q) side_min_q <= side;
								if (side > side_max_q) side_max_q <= side;
							end
						end
						if (cmd.close) begin
							state_q  <= ST_EMIT;
							k_q      <= '0;
							nch_q    <= cmd.nch;
							stereo_q <= cmd.stereo;
							bkt_q    <= cmd.bucket;
						end
					end
				end
				ST_EMIT: begin
					if (res_push) begin
						if (!k_is_last) begin
							k_q <= k_q + CH_W'(1);
						end else if (stereo_q) begin
							state_q <= ST_STEREO;
						end else begin
							// bucket done: empty all accumulators
							for (int i = 0; i < MAX_CH; i++) begin
								cmin_q[i] <= SAMPLE_MAX;
								cmax_q[i] <= SAMPLE_MIN;
							end
							mid_min_q  <= SAMPLE_MAX;
							mid_max_q  <= SAMPLE_MIN;
							side_min_q <= SAMPLE_MAX;
							side_max_q <= SAMPLE_MIN;
							state_q    <= ST_TAKE;
						end
					end
				end
				ST_STEREO: begin
					if (res_push) begin
						for (int i = 0; i < MAX_CH; i++) begin
							cmin_q[i] <= SAMPLE_MAX;
							cmax_q[i] <= SAMPLE_MIN;
						end
						mid_min_q  <= SAMPLE_MAX;
						mid_max_q  <= SAMPLE_MIN;
						side_min_q <= SAMPLE_MAX;
						side_max_q <= SAMPLE_MIN;
						state_q    <= ST_TAKE;
					end
				end
				default: begin
					state_q <= ST_TAKE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_close_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.close) |=> (state_q == ST_EMIT && k_q == '0))
		else $error("bucket close did not start result run at channel zero");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ({1'b0, k_q} < nch_q))
		else $error("result channel beyond channel count");

	a_stereo_only_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEREO) |-> (stereo_q && nch_q == NCH_W'(2)))
		else $error("mid/side result outside stereo");

	a_cleared_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEREO && res_push) |=>
		(state_q == ST_TAKE && mid_min_q == SAMPLE_MAX && side_max_q == SAMPLE_MIN))
		else $error("accumulators not emptied after bucket close");
`endif

endmodule

`default_nettype wire

### src/waveform_min_max_decimator_core.sv
// Top level of the min/max waveform decimator: front, command queue, back, result queue.
// Samples flow through the command queue to the back end, results through the result queue.
// Throughput: one sample per cycle while the command queue has room; at a bucket close
// the back end emits one result per channel, plus mid/side in stereo, taking no samples.
// Reset (arst_n low): queues empty, counters zero, accumulators empty, registers at defaults.
`default_nettype none

module waveform_min_max_decimator_core import fmmd_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int RES_DEPTH = RES_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire sample_t              sample,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [BKT_W-1:0]          bucket,
	output logic                      kind,
	output logic [CH_W-1:0]           channel,
	output sample_t                   low,
	output sample_t                   high,
	output sample_t                   side_low,
	output sample_t                   side_high,
	output logic                      last
);

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	assign full = cmd_full;

	fmmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.sample    (sample),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	fmmd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	fmmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	fmmd_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign bucket    = res_out.bucket;
	assign kind      = res_out.kind;
	assign channel   = res_out.channel;
	assign low       = res_out.low;
	assign high      = res_out.high;
	assign side_low  = res_out.side_low;
	assign side_high = res_out.side_high;
	assign last      = res_out.last;

endmodule

`default_nettype wire
